// ===== design/thal_pkg.sv =====
`timescale 1ns / 1ps

package thal_pkg;

  localparam int unsigned SMP_W   = 32;
  localparam int unsigned HYST_W  = 31;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned MODE_W  = 7;
  localparam int unsigned HITS_W  = 17;
  localparam int unsigned CIDX_W  = 3;

  // Register indexes on the configuration port.
  localparam logic [CIDX_W-1:0] REG_WARN_LOW  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_WARN_HIGH = 3'd1;
  localparam logic [CIDX_W-1:0] REG_FAIL_LOW  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_FAIL_HIGH = 3'd3;
  localparam logic [CIDX_W-1:0] REG_HYST      = 3'd4;
  localparam logic [CIDX_W-1:0] REG_HIT_LIMIT = 3'd5;
  localparam logic [CIDX_W-1:0] REG_MODE      = 3'd6;

  // Bit positions inside mode_bits.
  localparam int unsigned MB_WARN_LO_EN = 0;
  localparam int unsigned MB_WARN_HI_EN = 1;
  localparam int unsigned MB_FAIL_LO_EN = 2;
  localparam int unsigned MB_FAIL_HI_EN = 3;
  localparam int unsigned MB_INVERT     = 4;
  localparam int unsigned MB_PERSIST    = 5;
  localparam int unsigned MB_OK_REPEAT  = 6;

  // Stored level codes.
  localparam logic [1:0] LV_UNKNOWN = 2'd0;
  localparam logic [1:0] LV_OKAY    = 2'd1;
  localparam logic [1:0] LV_WARN    = 2'd2;
  localparam logic [1:0] LV_FAIL    = 2'd3;

  // Severity codes.
  localparam logic [1:0] SEV_OK   = 2'd0;
  localparam logic [1:0] SEV_WARN = 2'd1;
  localparam logic [1:0] SEV_FAIL = 2'd2;
  localparam logic [1:0] SEV_RSVD = 2'd3;

  // Side codes.
  localparam logic [1:0] SIDE_BELOW  = 2'd0;
  localparam logic [1:0] SIDE_ABOVE  = 2'd1;
  localparam logic [1:0] SIDE_WITHIN = 2'd2;

  typedef struct packed {
    logic signed [SMP_W-1:0] warn_low;
    logic signed [SMP_W-1:0] warn_high;
    logic signed [SMP_W-1:0] fail_low;
    logic signed [SMP_W-1:0] fail_high;
    logic [HYST_W-1:0]       hyst_amount;
    logic [LIMIT_W-1:0]      hit_limit;
    logic [MODE_W-1:0]       mode_bits;
  } cfg_t;

  typedef struct packed {
    logic [1:0] severity;
    logic [1:0] side;
  } class_t;

  typedef struct packed {
    logic notify;
    logic changed;
  } report_t;

endpackage

// ===== design/threshold_alarm_with_hysteresis_core.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------
// in       | in_valid / in_ready  | in_sample (signed Q16.16)
// out      | out_valid / out_ready| out_notify, out_severity, out_side, out_changed
// cfg      | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// A sample passes from its transfer through the input register and then the
// result register. One sample per cycle is sustained while out_ready stays high;
// the level and hit-count update sits between the two registers.
// Reset (rst_n low, synchronous) clears the stored level, the hit count, all
// configuration registers and both valid flags.
// When out_ready is low the result register holds and the input register can
// still take one more sample; in_ready drops once both are full.

module threshold_alarm_with_hysteresis_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [thal_pkg::SMP_W-1:0]   in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_notify,
  output logic [1:0]                          out_severity,
  output logic [1:0]                          out_side,
  output logic                                out_changed,
  input  logic                                cfg_we,
  input  logic [thal_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [thal_pkg::SMP_W-1:0]          cfg_wdata
);
  import thal_pkg::*;

  // Configuration registers. The user must write them only while the block is idle;
  // the block itself does not enforce this. The live values feed the datapath directly.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WARN_LOW:  cfg_r.warn_low    <= cfg_wdata;
        REG_WARN_HIGH: cfg_r.warn_high   <= cfg_wdata;
        REG_FAIL_LOW:  cfg_r.fail_low    <= cfg_wdata;
        REG_FAIL_HIGH: cfg_r.fail_high   <= cfg_wdata;
        REG_HYST:      cfg_r.hyst_amount <= cfg_wdata[HYST_W-1:0];
        REG_HIT_LIMIT: cfg_r.hit_limit   <= cfg_wdata[LIMIT_W-1:0];
        REG_MODE:      cfg_r.mode_bits   <= cfg_wdata[MODE_W-1:0];
        default:       ;  // indexes past the register list are ignored
      endcase
    end
  end

  // Input register. A sample moves on into the result stage whenever the
  // result register is empty or is being drained in the same cycle.
  logic                    a_valid_r;
  logic signed [SMP_W-1:0] a_sample_r;
  logic                    a_advance;

  assign a_advance = a_valid_r && (!out_valid || out_ready);
  assign in_ready  = !a_valid_r || a_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_sample_r <= in_sample;
    end
  end

  // Classification against the bounds uses the level left by the previous
  // sample; the tracker commits the new level at the same edge the result
  // register loads, so the next sample sees it right away.
  logic [1:0] level;
  class_t     cls;
  report_t    rep;

  thal_classify u_classify (
    .sample (a_sample_r),
    .cfg    (cfg_r),
    .level  (level),
    .cls    (cls)
  );

  thal_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (a_advance),
    .severity    (cls.severity),
    .hit_limit   (cfg_r.hit_limit),
    .persist     (cfg_r.mode_bits[MB_PERSIST]),
    .okay_repeat (cfg_r.mode_bits[MB_OK_REPEAT]),
    .level       (level),
    .rep         (rep)
  );

  // Result register.
  logic       out_valid_r;
  logic       out_notify_r;
  logic [1:0] out_severity_r;
  logic [1:0] out_side_r;
  logic       out_changed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance) begin
      out_notify_r   <= rep.notify;
      out_severity_r <= cls.severity;
      out_side_r     <= cls.side;
      out_changed_r  <= rep.changed;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_notify   = out_notify_r;
  assign out_severity = out_severity_r;
  assign out_side     = out_side_r;
  assign out_changed  = out_changed_r;

`ifndef SYNTHESIS
  a_input_stage_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !a_advance) |=> (a_valid_r && $stable(a_sample_r)))
    else $error("input register lost a waiting sample");

  a_severity_legal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_severity_r != SEV_RSVD))
    else $error("reserved severity code on a result");

  a_changed_notifies : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_changed_r) |-> out_notify_r)
    else $error("level change without notification");
`endif

endmodule

// ===== design/thal_classify.sv =====
`timescale 1ns / 1ps

module thal_classify (
  input  logic signed [thal_pkg::SMP_W-1:0] sample,
  input  thal_pkg::cfg_t                     cfg,
  input  logic [1:0]                         level,
  output thal_pkg::class_t                   cls
);
  import thal_pkg::*;

  // True when the sample lies outside the enabled bounds after the low bound
  // is raised and the high bound lowered by h. Sums are 34 bits, so exact.
  function automatic logic bound_out(logic signed [SMP_W-1:0] s,
                                     logic lo_en, logic signed [SMP_W-1:0] lo,
                                     logic hi_en, logic signed [SMP_W-1:0] hi,
                                     logic [HYST_W-1:0] h);
    logic signed [SMP_W+1:0] lo_w;
    logic signed [SMP_W+1:0] hi_n;
    logic signed [SMP_W+1:0] s_w;
    lo_w = {{2{lo[SMP_W-1]}}, lo} + {3'b000, h};
    hi_n = {{2{hi[SMP_W-1]}}, hi} - {3'b000, h};
    s_w  = {{2{s[SMP_W-1]}}, s};
    return (lo_en && (lo_w > s_w)) || (hi_en && (hi_n < s_w));
  endfunction

  logic [HYST_W-1:0]       hw;
  logic [HYST_W-1:0]       hf;
  logic                    w_out;
  logic                    f_out;
  logic                    inv;
  logic                    is_fail;
  logic                    is_warn;
  logic                    lo_en;
  logic                    hi_en;
  logic signed [SMP_W-1:0] lo;

  assign inv = cfg.mode_bits[MB_INVERT];
  assign hw  = (level == LV_WARN) ? cfg.hyst_amount : '0;
  assign hf  = (level == LV_FAIL) ? cfg.hyst_amount : '0;

  assign w_out = bound_out(sample, cfg.mode_bits[MB_WARN_LO_EN], cfg.warn_low,
                           cfg.mode_bits[MB_WARN_HI_EN], cfg.warn_high, hw);
  assign f_out = bound_out(sample, cfg.mode_bits[MB_FAIL_LO_EN], cfg.fail_low,
                           cfg.mode_bits[MB_FAIL_HI_EN], cfg.fail_high, hf);

  assign is_fail = inv ? !f_out : f_out;
  assign is_warn = inv ? !w_out : w_out;

  // The side comes from the bound pair of the classified level, without
  // hysteresis.
  assign lo_en = is_fail ? cfg.mode_bits[MB_FAIL_LO_EN] : cfg.mode_bits[MB_WARN_LO_EN];
  assign hi_en = is_fail ? cfg.mode_bits[MB_FAIL_HI_EN] : cfg.mode_bits[MB_WARN_HI_EN];
  assign lo    = is_fail ? cfg.fail_low : cfg.warn_low;

  always_comb begin
    cls.severity = is_fail ? SEV_FAIL : (is_warn ? SEV_WARN : SEV_OK);
    if (!is_fail && !is_warn) begin
      cls.side = SIDE_BELOW;
    end else if (inv) begin
      cls.side = (lo_en && hi_en) ? SIDE_WITHIN : (lo_en ? SIDE_ABOVE : SIDE_BELOW);
    end else begin
      cls.side = (lo_en && (sample < lo)) ? SIDE_BELOW : SIDE_ABOVE;
    end
  end

endmodule

// ===== design/thal_tracker.sv =====
`timescale 1ns / 1ps

module thal_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic [1:0]                    severity,
  input  logic [thal_pkg::LIMIT_W-1:0]  hit_limit,
  input  logic                          persist,
  input  logic                          okay_repeat,
  output logic [1:0]                    level,
  output thal_pkg::report_t             rep
);
  import thal_pkg::*;

  logic [1:0]        level_r;
  logic [1:0]        level_nxt;
  logic [HITS_W-1:0] hit_cnt_r;
  logic [HITS_W-1:0] hit_cnt_nxt;
  logic [1:0]        new_lv;
  logic              quiet_ok;
  logic              go;

  assign new_lv   = severity + 2'd1;
  assign quiet_ok = (severity == SEV_OK) && !okay_repeat;

  always_comb begin
    hit_cnt_nxt = hit_cnt_r;
    level_nxt   = level_r;
    go          = 1'b1;
    rep         = '0;
    if (hit_limit != '0) begin
      if (quiet_ok || (hit_cnt_r > {1'b0, hit_limit})) begin
        hit_cnt_nxt = '0;
      end else begin
        hit_cnt_nxt = hit_cnt_r + 1'b1;
        go          = 1'b0;
      end
    end
    if (go) begin
      if (new_lv == level_r) begin
        rep.notify = persist && !quiet_ok;
      end else begin
        level_nxt   = new_lv;
        rep.changed = 1'b1;
        rep.notify  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= LV_UNKNOWN;
      hit_cnt_r <= '0;
    end else if (upd) begin
      level_r   <= level_nxt;
      hit_cnt_r <= hit_cnt_nxt;
    end
  end

  assign level = level_r;

`ifndef SYNTHESIS
  a_level_known_stays : assert property (@(posedge clk) disable iff (!rst_n)
    (level_r != LV_UNKNOWN) |=> (level_r != LV_UNKNOWN))
    else $error("level fell back to unknown");

  a_changed_moves_level : assert property (@(posedge clk) disable iff (!rst_n)
    (upd && rep.changed) |=> (level_r != $past(level_r)))
    else $error("changed reported but level did not move");

  a_idle_holds_state : assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> ($stable(level_r) && $stable(hit_cnt_r)))
    else $error("state moved without an update");
`endif

endmodule
